@@ design/ramx_pkg.sv @@
`timescale 1ns / 1ps

package ramx_pkg;

    // sequence numbers and field widths
    localparam int SEQ_W     = 32;
    localparam int PEER_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int ACT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int NODES_DEF = 16;

    // event codes
    localparam logic [ACT_W-1:0] ACT_CLIENT_REQ  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLIENT_REL  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLIENT_DONE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PEER_REQ    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEER_REPLY  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEER_CLOSE  = 3'd5;

    // result codes
    localparam logic [KIND_W-1:0] MSG_GRANT   = 2'd0;
    localparam logic [KIND_W-1:0] MSG_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] MSG_REPLY   = 2'd2;
    localparam logic [KIND_W-1:0] MSG_CLOSE   = 2'd3;

    // configuration register indexes
    localparam logic CFG_SELF_INDEX = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    // results of the shared sequence compare unit
    typedef struct packed {
        logic              mine_first;
        logic              seq_greater;
        logic [SEQ_W-1:0]  next_own_seq;
    } seq_res_t;

endpackage

@@ design/ramx_seq_unit.sv @@
`timescale 1ns / 1ps

module ramx_seq_unit (
    input  logic [ramx_pkg::SEQ_W-1:0]  own_seq,
    input  logic [ramx_pkg::SEQ_W-1:0]  highest_seq,
    input  logic [ramx_pkg::SEQ_W-1:0]  seq_in,
    input  logic [ramx_pkg::PEER_W-1:0] self_index,
    input  logic [ramx_pkg::PEER_W-1:0] peer,
    output ramx_pkg::seq_res_t          res
);
    import ramx_pkg::*;

    // lower sequence wins, ties go to the lower index
    always_comb
    begin
        res.mine_first   = (own_seq < seq_in) ||
                           ((own_seq == seq_in) && (self_index < peer));
        res.seq_greater  = seq_in > highest_seq;
        res.next_own_seq = (highest_seq == {SEQ_W{1'b1}}) ? highest_seq
                                                           : highest_seq + SEQ_W'(1);
    end

endmodule

@@ design/ricart_agrawala_mutex_node.sv @@
`timescale 1ns / 1ps

// one node of ricart-agrawala mutual exclusion
// in channel: one event item per handshake (action, peer, seq_in); in_ready is high only
//   while the node is idle and no configuration write is offered, so events are handled
//   one at a time and never share an edge with a configuration write
// out channel: result items (msg_kind, dest, seq_out, last); last marks the final result
//   of an event, and an event that causes nothing gives no result at all
// cfg channel: cfg_index 0 writes self_index, 1 writes node_count; either write puts all
//   node state back to its start values under the new configuration; cfg_ready is high
//   while idle
// a peer event or a grant gives its result from the exec state, once the output slot is free
// a peer event passes through the exec state only and then returns to idle for the next event
// client request, release and done walk the peer flags with the scan counter, one peer per
//   cycle unless a stalled receiver holds it, over the effective node count (at most
//   min(NODES,16)), and the next event is taken once the scan is back in idle
// a stalled receiver holds the output register; the scan then waits on the next peer that
//   has a result and resumes when the result is taken
// reset: node 0 of 16 (clamped to NODES), all peers active, no request pending

module ricart_agrawala_mutex_node #(
    parameter int NODES = ramx_pkg::NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // event items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ramx_pkg::ACT_W-1:0]     action,
    input  logic [ramx_pkg::PEER_W-1:0]    peer,
    input  logic [ramx_pkg::SEQ_W-1:0]     seq_in,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ramx_pkg::KIND_W-1:0]    msg_kind,
    output logic [ramx_pkg::PEER_W-1:0]    dest,
    output logic [ramx_pkg::SEQ_W-1:0]     seq_out,
    output logic                           last,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [ramx_pkg::COUNT_W-1:0]   cfg_data
);
    import ramx_pkg::*;

    localparam int IDXW = (NODES > 1) ? $clog2(NODES) : 1;
    // peer fields are four bits wide, so at most sixteen nodes take part
    localparam int LIM = (NODES < 16) ? NODES : 16;
    localparam logic [COUNT_W-1:0] LIM_N = COUNT_W'(LIM);
    localparam logic [NODES-1:0] RST_ACTIVE = NODES'((64'(1) << LIM) - 64'(2));

    // control state
    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NODES-1:0]     deferred_reg, deferred_next;
    logic [NODES-1:0]     peer_active_reg, peer_active_next;
    logic [NODES-1:0]     awaiting_reg, awaiting_next;
    logic [COUNT_W-1:0]   active_peers_reg, active_peers_next;
    logic [COUNT_W-1:0]   replies_pending_reg, replies_pending_next;
    logic                 local_pending_reg, local_pending_next;
    logic [SEQ_W-1:0]     own_seq_reg, own_seq_next;
    logic [SEQ_W-1:0]     highest_seq_reg, highest_seq_next;
    logic                 finished_reg, finished_next;
    logic [PEER_W-1:0]    self_reg, self_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDXW-1:0]      scan_reg, scan_next;

    // latched event and output payload
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [PEER_W-1:0]    peer_reg, peer_next;
    logic [SEQ_W-1:0]     seq_in_reg, seq_in_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [PEER_W-1:0]    dest_reg, dest_next;
    logic [SEQ_W-1:0]     seq_out_reg, seq_out_next;
    logic                 last_reg, last_next;

    logic                 in_accept;
    logic                 cfg_accept;
    logic                 slot_free;
    logic [COUNT_W-1:0]   n_eff;
    logic [COUNT_W-1:0]   new_count;
    logic [PEER_W-1:0]    new_self;
    logic [COUNT_W-1:0]   n_new;
    logic [NODES-1:0]     start_active;
    logic [NODES-1:0]     scan_vec;
    logic [NODES-1:0]     above_mask;
    logic                 scan_hit;
    logic                 scan_last;
    logic                 scan_end;
    logic                 scan_advance;
    logic                 exec_scan;
    logic                 peer_ok;
    logic [IDXW-1:0]      pidx;
    logic [COUNT_W-1:0]   replies_dec;
    seq_res_t             seq_res;

    assign in_accept  = in_valid && in_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign slot_free  = !out_valid_reg || out_ready;

    // effective node count, clamped to [1, LIM]
    assign n_eff = (count_reg == '0) ? COUNT_W'(1) : ((count_reg > LIM_N) ? LIM_N : count_reg);

    // start values for a configuration write use the value being written
    assign new_self  = (cfg_index == CFG_SELF_INDEX) ? cfg_data[PEER_W-1:0] : self_reg;
    assign new_count = (cfg_index == CFG_NODE_COUNT) ? cfg_data : count_reg;
    assign n_new     = (new_count == '0) ? COUNT_W'(1)
                                         : ((new_count > LIM_N) ? LIM_N : new_count);

    assign pidx    = IDXW'(peer_reg);
    assign peer_ok = (COUNT_W'(peer_reg) < n_eff) && (peer_reg != self_reg);

    // shared sequence compare and increment
    ramx_seq_unit u_seq (
        .own_seq     (own_seq_reg),
        .highest_seq (highest_seq_reg),
        .seq_in      (seq_in_reg),
        .self_index  (self_reg),
        .peer        (peer_reg),
        .res         (seq_res)
    );

    // per-peer masks: start set and flags above the scan position
    for (genvar j = 0; j < NODES; j++)
    begin : g_mask
        assign start_active[j] = (j < int'(n_new)) && (j != int'(new_self));
        assign above_mask[j]   = (IDXW'(j) > scan_reg) && (j < int'(n_eff));
    end

    // flag vector walked by the scan: deferred for release, active peers otherwise
    assign scan_vec     = (act_reg == ACT_CLIENT_REL) ? deferred_reg : peer_active_reg;
    assign scan_hit     = scan_vec[scan_reg];
    assign scan_last    = (scan_vec & above_mask) == '0;
    assign scan_end     = 7'(scan_reg) == (7'(n_eff) - 7'd1);
    assign scan_advance = !scan_hit || slot_free;

    assign replies_dec = (replies_pending_reg != '0) ? replies_pending_reg - COUNT_W'(1)
                                                     : replies_pending_reg;

    // does the latched event need a walk over the peers
    always_comb
    begin
        exec_scan = 1'b0;
        if (!finished_reg)
        begin
            case (act_reg)
                ACT_CLIENT_REQ:  exec_scan = !local_pending_reg && (|peer_active_reg);
                ACT_CLIENT_REL:  exec_scan = local_pending_reg;
                ACT_CLIENT_DONE: exec_scan = 1'b1;
                default:         exec_scan = 1'b0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (slot_free)
                    state_next = exec_scan ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_advance && scan_end)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs; an offered configuration write goes first
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = !cfg_valid;
                cfg_ready = 1'b1;
            end
            ST_EXEC, ST_SCAN:
            begin
                in_ready  = 1'b0;
                cfg_ready = 1'b0;
            end
            default:
            begin
                in_ready  = 1'b0;
                cfg_ready = 1'b0;
            end
        endcase
    end

    // node state and result register
    always_comb
    begin
        logic             emit;
        logic [KIND_W-1:0] em_kind;
        logic [PEER_W-1:0] em_dest;
        logic [SEQ_W-1:0]  em_seq;
        logic              em_last;

        emit    = 1'b0;
        em_kind = MSG_GRANT;
        em_dest = '0;
        em_seq  = '0;
        em_last = 1'b1;

        deferred_next        = deferred_reg;
        peer_active_next     = peer_active_reg;
        awaiting_next        = awaiting_reg;
        active_peers_next    = active_peers_reg;
        replies_pending_next = replies_pending_reg;
        local_pending_next   = local_pending_reg;
        own_seq_next         = own_seq_reg;
        highest_seq_next     = highest_seq_reg;
        finished_next        = finished_reg;
        self_next            = self_reg;
        count_next           = count_reg;
        scan_next            = scan_reg;
        act_next             = act_reg;
        peer_next            = peer_reg;
        seq_in_next          = seq_in_reg;

        if (cfg_accept)
        begin
            if (cfg_index == CFG_SELF_INDEX)
                self_next = cfg_data[PEER_W-1:0];
            else
                count_next = cfg_data;
            deferred_next        = '0;
            awaiting_next        = '0;
            peer_active_next     = start_active;
            active_peers_next    = n_new;
            replies_pending_next = n_new;
            local_pending_next   = 1'b0;
            own_seq_next         = '0;
            highest_seq_next     = '0;
            finished_next        = 1'b0;
        end
        else if (in_accept)
        begin
            act_next    = action;
            peer_next   = peer;
            seq_in_next = seq_in;
        end
        else if (state_reg == ST_EXEC && slot_free)
        begin
            scan_next = '0;
            if (!finished_reg)
            begin
                case (act_reg)
                    ACT_CLIENT_REQ:
                    begin
                        if (!local_pending_reg)
                        begin
                            local_pending_next = 1'b1;
                            if (!(|peer_active_reg))
                                emit = 1'b1;
                            else
                            begin
                                own_seq_next         = seq_res.next_own_seq;
                                replies_pending_next = '0;
                            end
                        end
                    end
                    ACT_CLIENT_REL:
                    begin
                        local_pending_next = 1'b0;
                    end
                    ACT_CLIENT_DONE:
                    begin
                        finished_next = 1'b1;
                    end
                    ACT_PEER_REQ:
                    begin
                        if (peer_ok)
                        begin
                            if (seq_res.seq_greater)
                                highest_seq_next = seq_in_reg;
                            if (local_pending_reg && seq_res.mine_first)
                                deferred_next[pidx] = 1'b1;
                            else
                            begin
                                emit    = 1'b1;
                                em_kind = MSG_REPLY;
                                em_dest = peer_reg;
                            end
                        end
                    end
                    ACT_PEER_REPLY:
                    begin
                        if (peer_ok && local_pending_reg && awaiting_reg[pidx])
                        begin
                            awaiting_next[pidx]  = 1'b0;
                            replies_pending_next = replies_dec;
                            emit                 = replies_dec == '0;
                        end
                    end
                    ACT_PEER_CLOSE:
                    begin
                        if (peer_ok)
                        begin
                            if (awaiting_reg[pidx])
                            begin
                                awaiting_next[pidx]  = 1'b0;
                                replies_pending_next = replies_dec;
                                emit = (replies_dec == '0) && local_pending_reg;
                            end
                            if (peer_active_reg[pidx])
                            begin
                                peer_active_next[pidx] = 1'b0;
                                if (active_peers_reg != '0)
                                    active_peers_next = active_peers_reg - COUNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
        else if (state_reg == ST_SCAN && scan_advance)
        begin
            if (scan_hit)
            begin
                emit    = 1'b1;
                em_dest = PEER_W'(scan_reg);
                em_last = scan_last;
                case (act_reg)
                    ACT_CLIENT_REQ:
                    begin
                        em_kind                 = MSG_REQUEST;
                        em_seq                  = own_seq_reg;
                        awaiting_next[scan_reg] = 1'b1;
                        replies_pending_next    = replies_pending_reg + COUNT_W'(1);
                    end
                    ACT_CLIENT_REL:
                    begin
                        em_kind                 = MSG_REPLY;
                        deferred_next[scan_reg] = 1'b0;
                    end
                    default:
                    begin
                        em_kind = MSG_CLOSE;
                    end
                endcase
            end
            if (!scan_end)
                scan_next = scan_reg + IDXW'(1);
        end

        // output register: a new result replaces one being taken
        kind_next    = kind_reg;
        dest_next    = dest_reg;
        seq_out_next = seq_out_reg;
        last_next    = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = em_kind;
            dest_next      = em_dest;
            seq_out_next   = em_seq;
            last_next      = em_last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            out_valid_reg       <= 1'b0;
            deferred_reg        <= '0;
            peer_active_reg     <= RST_ACTIVE;
            awaiting_reg        <= '0;
            active_peers_reg    <= LIM_N;
            replies_pending_reg <= LIM_N;
            local_pending_reg   <= 1'b0;
            own_seq_reg         <= '0;
            highest_seq_reg     <= '0;
            finished_reg        <= 1'b0;
            self_reg            <= '0;
            count_reg           <= COUNT_W'(16);
            scan_reg            <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            out_valid_reg       <= out_valid_next;
            deferred_reg        <= deferred_next;
            peer_active_reg     <= peer_active_next;
            awaiting_reg        <= awaiting_next;
            active_peers_reg    <= active_peers_next;
            replies_pending_reg <= replies_pending_next;
            local_pending_reg   <= local_pending_next;
            own_seq_reg         <= own_seq_next;
            highest_seq_reg     <= highest_seq_next;
            finished_reg        <= finished_next;
            self_reg            <= self_next;
            count_reg           <= count_next;
            scan_reg            <= scan_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        peer_reg    <= peer_next;
        seq_in_reg  <= seq_in_next;
        kind_reg    <= kind_next;
        dest_reg    <= dest_next;
        seq_out_reg <= seq_out_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign msg_kind  = kind_reg;
    assign dest      = dest_reg;
    assign seq_out   = seq_out_reg;
    assign last      = last_reg;

`ifndef SYNTH
    // a reply is only awaited from a peer that is still active
    assert property (@(posedge clk) disable iff (!rst_n)
        (awaiting_reg & ~peer_active_reg) == '0)
        else $error("awaiting reply from inactive peer");

    // every active peer is counted in the active total
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(active_peers_reg) >= $countones(peer_active_reg))
        else $error("active peer count below active flags");

    // outstanding replies never exceed the node span
    assert property (@(posedge clk) disable iff (!rst_n)
        replies_pending_reg <= LIM_N)
        else $error("reply count out of range");
`endif

endmodule
